/* src/polynomial_waveshaper_dc_block_mix_core_assert.svh */
// assertion macros for the waveshaper core and its submodules
// no dependencies; included by files that carry concurrent assertions
`ifndef POLYNOMIAL_WAVESHAPER_DC_BLOCK_MIX_CORE_ASSERT_SVH
`define POLYNOMIAL_WAVESHAPER_DC_BLOCK_MIX_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PWDB_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pwdb assertion failed");

// next-cycle implication, disabled during reset
`define PWDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwdb assertion failed");

`endif

/* src/pwdb_pkg.sv */
// shared types and constants of the polynomial waveshaper / dc blocker / mixer
// no dependencies
package pwdb_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int COEF_BITS     = 32;
   localparam int GAIN_BITS     = 17;
   localparam int APB_ADDR_BITS = 4;
   localparam int APB_DATA_BITS = 32;

   localparam logic [GAIN_BITS-1:0] UNITY_Q16 = 17'd65536;
   localparam logic [GAIN_BITS-1:0] POLE_Q16  = 17'd65470;

   // shared multiply-add unit sizes
   localparam int MUL_A_BITS = COEF_BITS + 1;
   localparam int MUL_B_BITS = GAIN_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int ADD_BITS   = COEF_BITS + 2;

   typedef logic [2:0] alu_op_type;
   localparam alu_op_type ALU_HORNER = 3'd0;
   localparam alu_op_type ALU_BLOCK  = 3'd1;
   localparam alu_op_type ALU_GAIN   = 3'd2;
   localparam alu_op_type ALU_DRY    = 3'd3;
   localparam alu_op_type ALU_WET    = 3'd4;

   localparam logic [1:0] REG_DRY_GAIN = 2'd0;
   localparam logic [1:0] REG_VOLUME   = 2'd1;
   localparam logic [1:0] REG_PAN      = 2'd2;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   typedef struct packed {
      logic                          cmd;
      logic signed [SAMPLE_BITS-1:0] raw_left;
      logic signed [SAMPLE_BITS-1:0] raw_right;
      logic signed [SAMPLE_BITS-1:0] hp_left;
      logic signed [SAMPLE_BITS-1:0] hp_right;
      logic        [3:0]             coef_index;
      logic signed [COEF_BITS-1:0]   coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
   } rsp_type;

   // gains already limited to unity
   typedef struct packed {
      logic [GAIN_BITS-1:0] dry_gain;
      logic [GAIN_BITS-1:0] volume;
      logic [GAIN_BITS-1:0] pan;
   } gain_set_type;

endpackage

/* src/pwdb_csr.sv */
// apb-style configuration registers: dry gain, volume, pan
// depends on pwdb_pkg
module pwdb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pwdb_pkg::APB_ADDR_BITS-1:0]  paddr,
   input  logic [pwdb_pkg::APB_DATA_BITS-1:0]  pwdata,
   output logic [pwdb_pkg::APB_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output pwdb_pkg::gain_set_type              gains
);
   import pwdb_pkg::*;

   logic [GAIN_BITS-1:0] dry_ff, dry_in;
   logic [GAIN_BITS-1:0] vol_ff, vol_in;
   logic [GAIN_BITS-1:0] pan_ff, pan_in;
   logic                 wr_en;
   logic [1:0]           reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      dry_in = dry_ff;
      vol_in = vol_ff;
      pan_in = pan_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DRY_GAIN: dry_in = pwdata[GAIN_BITS-1:0];
            REG_VOLUME:   vol_in = pwdata[GAIN_BITS-1:0];
            REG_PAN:      pan_in = pwdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_ff <= '0;
         vol_ff <= UNITY_Q16;
         pan_ff <= 17'd32768;
      end else begin
         dry_ff <= dry_in;
         vol_ff <= vol_in;
         pan_ff <= pan_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DRY_GAIN: prdata = APB_DATA_BITS'(dry_ff);
         REG_VOLUME:   prdata = APB_DATA_BITS'(vol_ff);
         REG_PAN:      prdata = APB_DATA_BITS'(pan_ff);
         default:      prdata = '0;
      endcase
   end

   // values above unity act as unity
   assign gains.dry_gain = (dry_ff > UNITY_Q16) ? UNITY_Q16 : dry_ff;
   assign gains.volume   = (vol_ff > UNITY_Q16) ? UNITY_Q16 : vol_ff;
   assign gains.pan      = (pan_ff > UNITY_Q16) ? UNITY_Q16 : pan_ff;

endmodule

/* src/pwdb_alu.sv */
// shared multiply, floor shift, add and saturate unit
// depends on pwdb_pkg
module pwdb_alu (
   input  pwdb_pkg::alu_op_type                     op,
   input  logic signed [pwdb_pkg::MUL_A_BITS-1:0]   opa,
   input  logic signed [pwdb_pkg::MUL_B_BITS-1:0]   opb,
   input  logic signed [pwdb_pkg::ADD_BITS-1:0]     addend,
   output logic signed [pwdb_pkg::COEF_BITS-1:0]    result
);
   import pwdb_pkg::*;

   localparam logic signed [PROD_BITS:0] SAT32_HI = {{(PROD_BITS-30){1'b0}}, {31{1'b1}}};
   localparam logic signed [PROD_BITS:0] SAT32_LO = {{(PROD_BITS-30){1'b1}}, {31{1'b0}}};
   localparam logic signed [PROD_BITS:0] SMP_HI =
      {{(PROD_BITS+2-SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [PROD_BITS:0] SMP_LO =
      {{(PROD_BITS+2-SAMPLE_BITS){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [PROD_BITS-1:0] prod;
   logic signed [PROD_BITS-1:0] shifted;
   logic signed [PROD_BITS:0]   total;

   always_comb begin
      prod = opa * opb;
      // arithmetic right shift is a floor
      unique case (op)
         ALU_HORNER: shifted = prod >>> (SAMPLE_BITS - 1);
         ALU_BLOCK:  shifted = prod >>> 16;
         ALU_GAIN:   shifted = prod >>> 16;
         ALU_DRY:    shifted = prod >>> 16;
         ALU_WET:    shifted = prod >>> 17;
         default:    shifted = prod;
      endcase
      total = {shifted[PROD_BITS-1], shifted}
            + {{(PROD_BITS+1-ADD_BITS){addend[ADD_BITS-1]}}, addend};
      unique case (op)
         ALU_HORNER, ALU_BLOCK: begin
            if (total > SAT32_HI)      result = {1'b0, {31{1'b1}}};
            else if (total < SAT32_LO) result = {1'b1, {31{1'b0}}};
            else                       result = total[COEF_BITS-1:0];
         end
         ALU_WET: begin
            if (total > SMP_HI)
               result = {{(COEF_BITS+1-SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
            else if (total < SMP_LO)
               result = {{(COEF_BITS+1-SAMPLE_BITS){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
            else
               result = total[COEF_BITS-1:0];
         end
         default: result = total[COEF_BITS-1:0];
      endcase
   end

endmodule

/* src/polynomial_waveshaper_dc_block_mix_core.sv */
// stereo polynomial waveshaper with dc blocker and dry/wet mixer, top level
// depends on pwdb_pkg, pwdb_csr, pwdb_alu and the assertion macro header
//
// usage:
//   req channel (valid/ready) carries one transaction per item. cmd = CMD_COEF
//   writes coefficient coef_index (ignored when >= NUM_COEFS) and gives no
//   response. cmd = CMD_SAMPLE shapes both high-passed samples with the
//   degree NUM_COEFS-1 polynomial, runs the one-pole dc blocker per channel and
//   mixes with the dry samples; one rsp transaction follows.
//   all multiplications go through a single shared multiply-add unit, stepped by
//   the sequencer below: per channel NUM_COEFS-1 horner steps, then blocker,
//   wet gain, dry product and final mix.
//   a new sample is taken only once the previous result has left the
//   sequencer for the output register.
//   req_ready is high only while the sequencer is idle.
//   the result sits in an output register, so the next transaction is taken
//   while rsp is stalled; a finished result waits in the hold state until the
//   output register frees up.
//   reset (synchronous) clears coefficients, blocker state and returns the
//   csr to dry 0, volume unity, pan half.
//   the apb port is always ready; write it only while no sample is in flight.
module polynomial_waveshaper_dc_block_mix_core #(
   parameter int NUM_COEFS = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pwdb_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pwdb_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pwdb_pkg::APB_ADDR_BITS-1:0]  paddr,
   input  logic [pwdb_pkg::APB_DATA_BITS-1:0]  pwdata,
   output logic [pwdb_pkg::APB_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import pwdb_pkg::*;

   `include "polynomial_waveshaper_dc_block_mix_core_assert.svh"

   localparam int K_BITS = $clog2(NUM_COEFS);
   localparam logic [K_BITS-1:0] K_START = K_BITS'(NUM_COEFS - 2);
   localparam logic [K_BITS-1:0] K_TOP   = K_BITS'(NUM_COEFS - 1);

   // sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_HORNER = 3'd1;
   localparam logic [2:0] ST_BLOCK  = 3'd2;
   localparam logic [2:0] ST_GAIN   = 3'd3;
   localparam logic [2:0] ST_DRY    = 3'd4;
   localparam logic [2:0] ST_WET    = 3'd5;
   localparam logic [2:0] ST_HOLD   = 3'd6;

   logic [2:0]                    state_ff;
   logic [K_BITS-1:0]             k_ff;
   logic                          ch_ff;
   req_type                       sample_ff;
   logic signed [COEF_BITS-1:0]   acc_ff;
   logic [GAIN_BITS-1:0]          gain_ff;
   logic signed [SAMPLE_BITS-1:0] dry_ff;
   logic signed [SAMPLE_BITS-1:0] res_left_ff;
   logic signed [SAMPLE_BITS-1:0] res_right_ff;
   logic signed [COEF_BITS-1:0]   coef_ff [NUM_COEFS];
   logic signed [COEF_BITS-1:0]   prev_ff [2];
   logic signed [COEF_BITS-1:0]   blk_ff  [2];
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   gain_set_type                  gains;
   alu_op_type                    alu_op;
   logic signed [MUL_A_BITS-1:0]  alu_a;
   logic signed [MUL_B_BITS-1:0]  alu_b;
   logic signed [ADD_BITS-1:0]    alu_add;
   logic signed [COEF_BITS-1:0]   alu_res;

   logic                          req_fire;
   logic                          out_free;
   logic signed [SAMPLE_BITS-1:0] hp_sel;
   logic signed [SAMPLE_BITS-1:0] raw_sel;
   logic signed [COEF_BITS-1:0]   coef_k;
   logic signed [COEF_BITS-1:0]   prev_sel;
   logic signed [COEF_BITS-1:0]   blk_sel;
   logic [GAIN_BITS-1:0]          pan_sel;

   pwdb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .gains   (gains)
   );

   pwdb_alu u_alu (
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .addend (alu_add),
      .result (alu_res)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // channel selection for the operand mux
   assign hp_sel   = ch_ff ? sample_ff.hp_right  : sample_ff.hp_left;
   assign raw_sel  = ch_ff ? sample_ff.raw_right : sample_ff.raw_left;
   assign coef_k   = coef_ff[k_ff];
   assign prev_sel = prev_ff[ch_ff];
   assign blk_sel  = blk_ff[ch_ff];
   // right channel gets one minus pan
   assign pan_sel  = ch_ff ? (UNITY_Q16 - gains.pan) : gains.pan;

   // operand mux of the shared unit
   always_comb begin
      alu_op  = ALU_DRY;
      alu_a   = '0;
      alu_b   = '0;
      alu_add = '0;
      unique case (state_ff)
         ST_HORNER: begin
            alu_op  = ALU_HORNER;
            alu_a   = {acc_ff[COEF_BITS-1], acc_ff};
            alu_b   = {{(MUL_B_BITS-SAMPLE_BITS){hp_sel[SAMPLE_BITS-1]}}, hp_sel};
            alu_add = {{(ADD_BITS-COEF_BITS){coef_k[COEF_BITS-1]}}, coef_k};
         end
         ST_BLOCK: begin
            // b = 0.999 b + y - y_prev
            alu_op  = ALU_BLOCK;
            alu_a   = {blk_sel[COEF_BITS-1], blk_sel};
            alu_b   = {1'b0, POLE_Q16};
            alu_add = {{(ADD_BITS-COEF_BITS){acc_ff[COEF_BITS-1]}}, acc_ff}
                    - {{(ADD_BITS-COEF_BITS){prev_sel[COEF_BITS-1]}}, prev_sel};
         end
         ST_GAIN: begin
            alu_op = ALU_GAIN;
            alu_a  = {{(MUL_A_BITS-GAIN_BITS){1'b0}}, gains.volume};
            alu_b  = {1'b0, pan_sel};
         end
         ST_DRY: begin
            alu_op = ALU_DRY;
            alu_a  = {{(MUL_A_BITS-SAMPLE_BITS){raw_sel[SAMPLE_BITS-1]}}, raw_sel};
            alu_b  = {1'b0, gains.dry_gain};
         end
         ST_WET: begin
            // wet term drops one extra bit to go from q16 to q15
            alu_op  = ALU_WET;
            alu_a   = {acc_ff[COEF_BITS-1], acc_ff};
            alu_b   = {1'b0, gain_ff};
            alu_add = {{(ADD_BITS-SAMPLE_BITS){dry_ff[SAMPLE_BITS-1]}}, dry_ff};
         end
         default: ;
      endcase
   end

   // sequencer and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COEFS; i++) coef_ff[i] <= '0;
         for (int i = 0; i < 2; i++) begin
            prev_ff[i] <= '0;
            blk_ff[i]  <= '0;
         end
      end else begin
         // the hold state reloads the output slot itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_HOLD) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_data.cmd == CMD_COEF) begin
                     if (32'(req_data.coef_index) < NUM_COEFS)
                        coef_ff[req_data.coef_index[K_BITS-1:0]] <= req_data.coef_value;
                  end else begin
                     sample_ff <= req_data;
                     acc_ff    <= coef_ff[K_TOP];
                     k_ff      <= K_START;
                     ch_ff     <= 1'b0;
                     state_ff  <= ST_HORNER;
                  end
               end
            end
            ST_HORNER: begin
               acc_ff <= alu_res;
               if (k_ff == '0) state_ff <= ST_BLOCK;
               else            k_ff     <= k_ff - 1'b1;
            end
            ST_BLOCK: begin
               blk_ff[ch_ff]  <= alu_res;
               prev_ff[ch_ff] <= acc_ff;
               acc_ff         <= alu_res;
               state_ff       <= ST_GAIN;
            end
            ST_GAIN: begin
               gain_ff  <= alu_res[GAIN_BITS-1:0];
               state_ff <= ST_DRY;
            end
            ST_DRY: begin
               dry_ff   <= alu_res[SAMPLE_BITS-1:0];
               state_ff <= ST_WET;
            end
            ST_WET: begin
               if (ch_ff == 1'b0) begin
                  res_left_ff <= alu_res[SAMPLE_BITS-1:0];
                  ch_ff       <= 1'b1;
                  acc_ff      <= coef_ff[K_TOP];
                  k_ff        <= K_START;
                  state_ff    <= ST_HORNER;
               end else begin
                  res_right_ff <= alu_res[SAMPLE_BITS-1:0];
                  state_ff     <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               // wait until the output register is free
               if (out_free) begin
                  rsp_data_ff.out_left  <= res_left_ff;
                  rsp_data_ff.out_right <= res_right_ff;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // horner counter never runs past the second highest coefficient
   `PWDB_ASSERT_HOLDS(a_k_range, clock, reset, state_ff == ST_HORNER, k_ff <= K_START)
   // a sample transaction starts the left channel horner loop
   `PWDB_ASSERT_NEXT(a_sample_start, clock, reset, req_fire && req_data.cmd == CMD_SAMPLE,
      state_ff == ST_HORNER && ch_ff == 1'b0)
   // a coefficient transaction leaves the block idle
   `PWDB_ASSERT_NEXT(a_coef_idle, clock, reset, req_fire && req_data.cmd == CMD_COEF,
      state_ff == ST_IDLE)
   // a held result moves to the output as soon as the slot is free
   `PWDB_ASSERT_NEXT(a_hold_release, clock, reset, state_ff == ST_HOLD && out_free,
      rsp_valid_ff && state_ff == ST_IDLE)
   // wet gain never exceeds unity
   `PWDB_ASSERT_HOLDS(a_gain_range, clock, reset, state_ff == ST_DRY, gain_ff <= UNITY_Q16)

endmodule
